// ===== hdl/servo_command_frame_builder_defines.svh =====
// Assertion macros shared by the servo frame builder checker.
`ifndef SERVO_COMMAND_FRAME_BUILDER_DEFINES_SVH
`define SERVO_COMMAND_FRAME_BUILDER_DEFINES_SVH

// Same-cycle implication on clk_i, off while rst_ni is low.
`define SCF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("servo frame builder: same-cycle check failed");

// Next-cycle implication on clk_i, off while rst_ni is low.
`define SCF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("servo frame builder: next-cycle check failed");

`endif

// ===== hdl/scf_pkg.sv =====
// Types and constants of the servo command frame builder.
`timescale 1ns / 1ps
package scf_pkg;

  typedef enum logic {
    OP_MOVE   = 1'b0,
    OP_SET_ID = 1'b1
  } op_e;

  localparam logic [7:0]  HDR_BYTE  = 8'h55;
  localparam logic [7:0]  MOVE_CMD  = 8'd1;
  localparam logic [7:0]  MOVE_LEN  = 8'd7;
  localparam logic [7:0]  SETID_CMD = 8'd13;
  localparam logic [7:0]  SETID_LEN = 8'd4;
  localparam logic [10:0] UNITS_MAX = 11'd1000;
  // floor(y / 3) for y below 4096 as (y * 2731) >> 13
  localparam logic [11:0] RECIP3    = 12'd2731;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // byte positions within a frame
  localparam logic [3:0] IDX_HDR0 = 4'd0;
  localparam logic [3:0] IDX_HDR1 = 4'd1;
  localparam logic [3:0] IDX_ID   = 4'd2;
  localparam logic [3:0] IDX_LEN  = 4'd3;
  localparam logic [3:0] IDX_CMD  = 4'd4;
  localparam logic [3:0] IDX_P0   = 4'd5;
  localparam logic [3:0] IDX_P1   = 4'd6;
  localparam logic [3:0] IDX_P2   = 4'd7;
  localparam logic [3:0] IDX_P3   = 4'd8;
  localparam logic [3:0] IDX_MOVE_LAST  = 4'd9;
  localparam logic [3:0] IDX_SETID_LAST = 4'd6;

  typedef struct packed {
    op_e        op;
    logic [7:0] id;
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
    logic [7:0] p3;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_beat_t;

endpackage

// ===== hdl/servo_command_frame_builder.sv =====
// Top level of the servo command frame builder.
`timescale 1ns / 1ps
// Usage:
//   Command channel: a command beat is taken at a rising edge with start_i
//   high and busy_o low; operation_i selects move (angle and time) or set-ID.
//   Byte channel: each frame byte shows on tx_byte_o for one cycle with
//   tx_valid_o high; last_byte_o marks the checksum byte closing the frame.
//   Frames are two 0x55 bytes, ID, length, command, parameters, checksum.
// Path: a taken command passes front stages A and B and the queue; the first
//   byte of its frame is then registered out when the byte side is idle.
// Throughput: one byte per cycle while a command is queued; a move frame has
//   10 bytes and a set-ID frame 7, from the single byte-wide output sequencer.
//   Frames follow each other back to back when the next command is queued.
// Buffering: a two-stage front pipeline feeds a two-entry command queue;
//   busy_o is high while the queue plus in-flight commands are full.
// Reset: asynchronous, clears the pipeline, queue and sequencer; no strobe
//   is given until a command is taken. The receiver cannot stall the
//   byte channel, so no back-pressure exists on that side.
module servo_command_frame_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        operation_i,
  input  logic [7:0]  servo_id_i,
  input  logic [15:0] angle_deg_q8_i,
  input  logic [14:0] time_ms_i,
  input  logic [7:0]  new_id_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_byte_o
);
  import scf_pkg::*;

  q_beat_t           push;
  q_beat_t           head;
  logic              pop;
  logic [QCNT_W-1:0] q_count;

  scf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .servo_id_i     (servo_id_i),
    .angle_deg_q8_i (angle_deg_q8_i),
    .time_ms_i      (time_ms_i),
    .new_id_i       (new_id_i),
    .q_count_i      (q_count),
    .push_o         (push)
  );

  scf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (q_count)
  );

  scf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .tx_valid_o  (tx_valid_o),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

// ===== hdl/scf_queue.sv =====
// Short command queue between the front and back parts.
`timescale 1ns / 1ps
module scf_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  scf_pkg::q_beat_t       push_i,
  input  logic                   pop_i,
  output scf_pkg::q_beat_t       head_o,
  output logic [scf_pkg::QCNT_W-1:0] count_o
);
  import scf_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_pop;

  assign do_pop       = pop_i && (count_q != '0);
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign count_o      = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i.valid && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i.valid && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/scf_front.sv =====
// Front part: takes commands, converts the angle, builds parameter bytes.
`timescale 1ns / 1ps
module scf_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       operation_i,
  input  logic [7:0]                 servo_id_i,
  input  logic [15:0]                angle_deg_q8_i,
  input  logic [14:0]                time_ms_i,
  input  logic [7:0]                 new_id_i,
  input  logic [scf_pkg::QCNT_W-1:0] q_count_i,
  output scf_pkg::q_beat_t           push_o
);
  import scf_pkg::*;

  logic              take;
  logic [QCNT_W:0]   inflight;
  logic [20:0]       x_d;

  logic              va_q;
  op_e               op_a_q;
  logic [7:0]        id_a_q;
  logic [7:0]        nid_a_q;
  logic [14:0]       tms_a_q;
  logic [20:0]       x_a_q;

  logic [23:0]       prod;
  logic [10:0]       units_raw;
  logic [10:0]       units;
  cmd_t              cmd_d;

  logic              vb_q;
  cmd_t              cmd_b_q;

  // everything in flight must fit in the queue
  assign inflight = {1'b0, q_count_i} + {{QCNT_W{1'b0}}, va_q} + {{QCNT_W{1'b0}}, vb_q};
  assign busy_o   = (inflight >= (QCNT_W + 1)'(QDEPTH));
  assign take     = start_i && !busy_o;

  // q8 angle times 25
  assign x_d = {1'b0, angle_deg_q8_i, 4'b0} + {2'b0, angle_deg_q8_i, 3'b0}
             + {5'b0, angle_deg_q8_i};

  assign prod      = 24'(x_a_q[20:9]) * 24'(RECIP3);
  assign units_raw = prod[23:13];
  assign units     = (units_raw > UNITS_MAX) ? UNITS_MAX : units_raw;

  always_comb begin
    cmd_d.op = op_a_q;
    cmd_d.id = id_a_q;
    case (op_a_q)
      OP_MOVE: begin
        cmd_d.p0 = units[7:0];
        cmd_d.p1 = {5'b0, units[10:8]};
        cmd_d.p2 = tms_a_q[7:0];
        cmd_d.p3 = {1'b0, tms_a_q[14:8]};
      end
      OP_SET_ID: begin
        cmd_d.p0 = nid_a_q;
        cmd_d.p1 = '0;
        cmd_d.p2 = '0;
        cmd_d.p3 = '0;
      end
      default: begin
        cmd_d.p0 = '0;
        cmd_d.p1 = '0;
        cmd_d.p2 = '0;
        cmd_d.p3 = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_a_q  <= op_e'(operation_i);
      id_a_q  <= servo_id_i;
      nid_a_q <= new_id_i;
      tms_a_q <= time_ms_i;
      x_a_q   <= x_d;
    end
    if (va_q) begin
      cmd_b_q <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= take;
      vb_q <= va_q;
    end
  end

  assign push_o.valid = vb_q;
  assign push_o.cmd   = cmd_b_q;

endmodule

// ===== hdl/scf_back.sv =====
// Back part: walks a queued command out as frame bytes with running checksum.
`timescale 1ns / 1ps
module scf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  scf_pkg::q_beat_t head_i,
  output logic             pop_o,
  output logic             tx_valid_o,
  output logic [7:0]       tx_byte_o,
  output logic             last_byte_o
);
  import scf_pkg::*;

  logic [3:0] idx_q, idx_d;
  logic [7:0] sum_q, sum_d;
  logic [3:0] last_idx;
  logic       is_last;
  logic [7:0] byte_d;
  logic       tx_valid_q;
  logic [7:0] tx_byte_q;
  logic       last_q;

  assign last_idx = (head_i.cmd.op == OP_MOVE) ? IDX_MOVE_LAST : IDX_SETID_LAST;
  assign is_last  = (idx_q == last_idx);

  always_comb begin
    case (idx_q)
      IDX_HDR0: byte_d = HDR_BYTE;
      IDX_HDR1: byte_d = HDR_BYTE;
      IDX_ID:   byte_d = head_i.cmd.id;
      IDX_LEN:  byte_d = (head_i.cmd.op == OP_MOVE) ? MOVE_LEN : SETID_LEN;
      IDX_CMD:  byte_d = (head_i.cmd.op == OP_MOVE) ? MOVE_CMD : SETID_CMD;
      IDX_P0:   byte_d = head_i.cmd.p0;
      IDX_P1:   byte_d = head_i.cmd.p1;
      IDX_P2:   byte_d = head_i.cmd.p2;
      IDX_P3:   byte_d = head_i.cmd.p3;
      default:  byte_d = '0;
    endcase
    if (is_last) begin
      byte_d = ~sum_q;
    end
  end

  always_comb begin
    sum_d = sum_q;
    idx_d = idx_q;
    pop_o = 1'b0;
    if (head_i.valid) begin
      if (idx_q == IDX_ID) begin
        sum_d = byte_d;
      end else if (!is_last) begin
        sum_d = sum_q + byte_d;
      end
      if (is_last) begin
        idx_d = IDX_HDR0;
        pop_o = 1'b1;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q     <= sum_d;
    tx_byte_q <= byte_d;
    last_q    <= is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= IDX_HDR0;
      tx_valid_q <= 1'b0;
    end else begin
      idx_q      <= idx_d;
      tx_valid_q <= head_i.valid;
    end
  end

  assign tx_valid_o  = tx_valid_q;
  assign tx_byte_o   = tx_byte_q;
  assign last_byte_o = tx_valid_q && last_q;

endmodule

// ===== hdl/scf_checker.sv =====
// Port-level checks on the servo frame builder, bound to the top level.
`timescale 1ns / 1ps
`include "servo_command_frame_builder_defines.svh"
module scf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       tx_valid_o,
  input logic [7:0] tx_byte_o,
  input logic       last_byte_o
);
  import scf_pkg::*;

  // a frame opens with a header byte
  `SCF_ASSERT_NOW(a_frame_opens_hdr, $rose(tx_valid_o), tx_byte_o == HDR_BYTE)
  // bytes of one frame come without gaps
  `SCF_ASSERT_NEXT(a_frame_contiguous, tx_valid_o && !last_byte_o, tx_valid_o)
  // a frame straight after a checksum starts with a header byte
  `SCF_ASSERT_NEXT(a_next_frame_hdr, tx_valid_o && last_byte_o,
                   !tx_valid_o || (tx_byte_o == HDR_BYTE))
  // a header byte is never the checksum of a frame that just opened
  `SCF_ASSERT_NOW(a_first_not_last, $rose(tx_valid_o), !last_byte_o)
  // busy only rises after a beat is taken
  `SCF_ASSERT_NEXT(a_busy_needs_take, !busy_o && !start_i, !busy_o)

endmodule

bind servo_command_frame_builder scf_checker u_scf_checker (.*);

// ===== tb/servo_frame_checker.sv =====
// Checker for the servo command frame builder: predicts each frame and compares its bytes.
`timescale 1ns / 1ps
module servo_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        operation_i,
  input  logic [7:0]  servo_id_i,
  input  logic [15:0] angle_deg_q8_i,
  input  logic [14:0] time_ms_i,
  input  logic [7:0]  new_id_i,
  input  logic        tx_valid_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        last_byte_i,
  output int          mismatches_o,
  output int          pending_o
);
  import scf_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  frame_byte_t frame_bytes_q[$];

  function automatic logic [10:0] angle_to_units(logic [15:0] ang);
    int unsigned units;
    units = (int'(ang) * 25) / 1536;
    if (units > int'(UNITS_MAX)) units = int'(UNITS_MAX);
    return units[10:0];
  endfunction

  function automatic void queue_frame(op_e op, logic [7:0] id, logic [15:0] ang,
                                      logic [14:0] tms, logic [7:0] nid);
    logic [7:0]  body [9];
    logic [7:0]  sum;
    logic [10:0] units;
    int          n;
    units = angle_to_units(ang);
    body[0] = HDR_BYTE;
    body[1] = HDR_BYTE;
    body[2] = id;
    if (op == OP_MOVE) begin
      body[3] = MOVE_LEN;
      body[4] = MOVE_CMD;
      body[5] = units[7:0];
      body[6] = {5'd0, units[10:8]};
      body[7] = tms[7:0];
      body[8] = {1'b0, tms[14:8]};
      n = 9;
    end else begin
      body[3] = SETID_LEN;
      body[4] = SETID_CMD;
      body[5] = nid;
      n = 6;
    end
    sum = 8'd0;
    for (int i = 0; i < n; i++) begin
      frame_bytes_q.push_back('{data: body[i], last: 1'b0});
      if (i >= 2) sum = sum + body[i];
    end
    frame_bytes_q.push_back('{data: ~sum, last: 1'b1});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_byte_t exp_byte;
    if (!rst_ni) begin
      frame_bytes_q.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (tx_valid_i) begin
        if (frame_bytes_q.size() == 0) begin
          if (mismatches_o < 10)
            $display("%0t: byte 0x%02h last %0b with no frame byte due",
                     $time, tx_byte_i, last_byte_i);
          mismatches_o <= mismatches_o + 1;
        end else begin
          exp_byte = frame_bytes_q.pop_front();
          if (tx_byte_i !== exp_byte.data || last_byte_i !== exp_byte.last) begin
            if (mismatches_o < 10)
              $display("%0t: byte exp 0x%02h last %0b, got 0x%02h last %0b",
                       $time, exp_byte.data, exp_byte.last, tx_byte_i, last_byte_i);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      if (start_i && !busy_i)
        queue_frame(op_e'(operation_i), servo_id_i, angle_deg_q8_i, time_ms_i, new_id_i);
      pending_o <= frame_bytes_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the servo command frame builder bench: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
  import scf_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 70;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        operation;
  logic [7:0]  servo_id;
  logic [15:0] angle_deg_q8;
  logic [14:0] time_ms;
  logic [7:0]  new_id;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        last_byte;
  int          mismatches;
  int          pending;
  int          idle_pct;
  int          quiet_cycles = 0;

  servo_command_frame_builder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_o        (busy),
    .operation_i   (operation),
    .servo_id_i    (servo_id),
    .angle_deg_q8_i(angle_deg_q8),
    .time_ms_i     (time_ms),
    .new_id_i      (new_id),
    .tx_valid_o    (tx_valid),
    .tx_byte_o     (tx_byte),
    .last_byte_o   (last_byte)
  );

  servo_frame_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .operation_i   (operation),
    .servo_id_i    (servo_id),
    .angle_deg_q8_i(angle_deg_q8),
    .time_ms_i     (time_ms),
    .new_id_i      (new_id),
    .tx_valid_i    (tx_valid),
    .tx_byte_i     (tx_byte),
    .last_byte_i   (last_byte),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((start && !busy) || tx_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL servo_command_frame_builder");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(input op_e op, input logic [7:0] id, input logic [15:0] ang,
                          input logic [14:0] tms, input logic [7:0] nid);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    operation    <= op;
    servo_id     <= id;
    angle_deg_q8 <= ang;
    time_ms      <= tms;
    new_id       <= nid;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_random_cmd();
    logic [15:0] ang;
    logic [14:0] tms;
    case ($urandom_range(3))
      0: ang = 16'($urandom_range(65535));
      1: ang = 16'($urandom_range(61440 + 96, 61440 - 96));
      2: ang = 16'($urandom_range(4095));
      default: ang = 16'($urandom_range(61439));
    endcase
    if ($urandom_range(9) == 0) tms = 15'($urandom_range(32767, 30001));
    else tms = 15'($urandom_range(30000));
    send_cmd(op_e'($urandom_range(1)), 8'($urandom_range(255)), ang, tms,
             8'($urandom_range(255)));
  endtask

  task automatic drain_frames();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    operation    = 1'b0;
    servo_id     = '0;
    angle_deg_q8 = '0;
    time_ms      = '0;
    new_id       = '0;
    idle_pct     = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, the 240 degree saturation knee, time above range, both ops
    send_cmd(OP_MOVE,   8'd0,   16'd0,     15'd0,     8'd0);
    send_cmd(OP_MOVE,   8'd255, 16'd65535, 15'd30000, 8'd255);
    send_cmd(OP_MOVE,   8'd1,   16'd61439, 15'd1,     8'd0);
    send_cmd(OP_MOVE,   8'd2,   16'd61440, 15'd32767, 8'd0);
    send_cmd(OP_MOVE,   8'd3,   16'd61441, 15'd30001, 8'd0);
    send_cmd(OP_MOVE,   8'd4,   16'd61502, 15'd256,   8'd0);
    send_cmd(OP_MOVE,   8'd5,   16'd61503, 15'd255,   8'd0);
    send_cmd(OP_MOVE,   8'd6,   16'd61,    15'd12345, 8'd170);
    send_cmd(OP_MOVE,   8'd7,   16'd62,    15'd21845, 8'd85);
    send_cmd(OP_MOVE,   8'd170, 16'd32768, 15'd10922, 8'd0);
    send_cmd(OP_SET_ID, 8'd0,   16'd0,     15'd0,     8'd0);
    send_cmd(OP_SET_ID, 8'd255, 16'd65535, 15'd32767, 8'd255);
    send_cmd(OP_SET_ID, 8'd85,  16'd61440, 15'd30000, 8'd170);
    send_cmd(OP_SET_ID, 8'd1,   16'd1234,  15'd1,     8'd254);
    send_cmd(OP_MOVE,   8'd254, 16'd1536,  15'd1000,  8'd1);
    send_cmd(OP_SET_ID, 8'd254, 16'd0,     15'd0,     8'd1);
    drain_frames();

    idle_pct = 32;
    repeat (ITEMS_PER_PHASE) send_random_cmd();
    drain_frames();

    idle_pct = 87;
    repeat (ITEMS_PER_PHASE) send_random_cmd();
    drain_frames();

    idle_pct = 0;
    repeat (ITEMS_PER_PHASE) send_random_cmd();
    drain_frames();
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS servo_command_frame_builder");
    end else begin
      $display("FAIL servo_command_frame_builder");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/scf_pkg.sv
hdl/scf_queue.sv
hdl/scf_front.sv
hdl/scf_back.sv
hdl/servo_command_frame_builder.sv
hdl/scf_checker.sv
tb/servo_frame_checker.sv
tb/testbench.sv
